>>> rtl/core/aets_pkg.sv
// ---------------------------------------------------------------------------
// aets_pkg: shared types and codes for the endurance test sequencer
// operation, status, motion, jog, register index and sequencer state codes
// ---------------------------------------------------------------------------
`default_nettype none
package aets_pkg;
	typedef enum logic [2:0] {
		OP_TICK = 3'd0, OP_START = 3'd1, OP_PAUSE = 3'd2,
		OP_STOP = 3'd3, OP_JOG_OPEN = 3'd4, OP_JOG_CLOSE = 3'd5
	} op_t;
	typedef enum logic [2:0] {
		ST_DONE = 3'd0, ST_RUN = 3'd1, ST_PAUSED = 3'd2,
		ST_STOPPED = 3'd3, ST_HOT = 3'd4, ST_FAULT = 3'd5
	} status_t;
	typedef enum logic [1:0] {
		MO_IDLE = 2'd0, MO_OPEN = 2'd1, MO_CLOSE = 2'd2
	} motion_t;
	typedef enum logic [1:0] {
		JOG_NONE = 2'd0, JOG_OPEN = 2'd1, JOG_CLOSE = 2'd2, JOG_HOME = 2'd3
	} jog_t;
	typedef enum logic [2:0] {
		R_MODE = 3'd0, R_MOVE = 3'd1, R_COOL = 3'd2, R_SCUR = 3'd3,
		R_SDLY = 3'd4, R_FAULT = 3'd5, R_STEMP = 3'd6, R_TARGET = 3'd7
	} reg_t;
	typedef enum logic [1:0] {
		SQ_IDLE, SQ_DIV, SQ_DONE
	} seq_t;
	localparam int unsigned SUM_BITS = 32;
	localparam int unsigned CNT_BITS = 16;
endpackage
`default_nettype wire

>>> rtl/core/aets_if.sv
// ---------------------------------------------------------------------------
// aets_if: valid/ready channel with a packed payload
// generic word channel, source and sink views
// ---------------------------------------------------------------------------
`default_nettype none
interface aets_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/aets_div.sv
// ---------------------------------------------------------------------------
// aets_div: serial restoring divider
// one quotient bit a cycle, current sum over sample count
// ---------------------------------------------------------------------------
`default_nettype none
module aets_div
	import aets_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SUM_BITS-1:0] dividend,
	input  wire logic [CNT_BITS-1:0] divisor,
	output logic                     busy,
	output logic [SUM_BITS-1:0]      quotient
);
	logic [SUM_BITS-1:0] q_q;
	logic [CNT_BITS:0]   rem_q;
	logic [CNT_BITS-1:0] dvs_q;
	logic [5:0]          cnt_q;
	logic [CNT_BITS:0]   trial;
	logic [CNT_BITS:0]   shifted;

	assign shifted  = {rem_q[CNT_BITS-1:0], q_q[SUM_BITS-1]};
	assign trial    = shifted - {1'b0, dvs_q};
	assign busy     = (cnt_q != 6'd0);
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'(SUM_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[CNT_BITS]) begin
				rem_q <= trial;
				q_q   <= {q_q[SUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[SUM_BITS-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/actuator_endurance_test_sequencer_unit.sv
// ---------------------------------------------------------------------------
// actuator_endurance_test_sequencer_unit: open/close endurance sequencer
// ---------------------------------------------------------------------------
// in_ch carries one word per 1 ms tick or command: operation, motor_current,
// grip_force, temperature. out_ch returns exactly one status word per input
// word: drive lines, status, motion, position, cycle count, mean current and
// peak force. cfg_ch writes the eight setup registers by index; write only
// while idle.
// the status word is registered and offered in the cycle after the input word
// is taken; a word on which the current stop fires first runs the serial
// divider for the mean current (one quotient bit a cycle over the 32-bit
// current sum), and its status word is offered once the divider is done and
// the sequencer has passed its done state. one word is in flight at a time:
// no new word is taken until the last status word has been taken.
// reset: setup registers take their defaults, status is stopped, idle, open,
// cooling timer running, all counters cleared.
// a stalled receiver holds the result word in the output register and the
// block takes no new word until it is drained.
// ---------------------------------------------------------------------------
`default_nettype none
module actuator_endurance_test_sequencer_unit
	import aets_pkg::*;
#(
	parameter int TIMER_BITS  = 16,
	parameter int SAMPLE_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	aets_if.sink     in_ch,
	aets_if.source   out_ch,
	aets_if.sink     cfg_ch
);
	localparam int TB = TIMER_BITS;
	localparam logic [TB-1:0] TMAX = '1;
	// usable sample bits, also the ceiling of the mean
	localparam logic [11:0] CUR_MASK =
		(SAMPLE_BITS >= 12) ? 12'hFFF : 12'((1 << SAMPLE_BITS) - 1);

	// input word: operation[2:0], motor_current, grip_force, temperature
	logic [2:0]             operation;
	logic [11:0]            motor_current;
	logic signed [15:0]     grip_force;
	logic signed [7:0]      temperature;
	logic [11:0]            cur_s;
	assign {operation, motor_current, grip_force, temperature} = in_ch.data;
	assign cur_s = motor_current & CUR_MASK;

	// setup registers
	logic [1:0]  mode_q;
	logic [15:0] move_q, cool_t_q, sdly_q, fault_q, target_q;
	logic [11:0] scur_q;
	logic signed [7:0] stemp_q;
	logic [2:0]  cidx;
	logic [15:0] cval;
	assign cidx = cfg_ch.data[18:16];
	assign cval = cfg_ch.data[15:0];
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd1; move_q <= 16'd600; cool_t_q <= 16'd1000;
			scur_q <= 12'd4095; sdly_q <= 16'd100; fault_q <= 16'd5000;
			stemp_q <= 8'sd60; target_q <= 16'd0;
		end else if (cfg_ch.valid) begin
			unique case (reg_t'(cidx))
				R_MODE:   mode_q   <= cval[1:0];
				R_MOVE:   move_q   <= cval;
				R_COOL:   cool_t_q <= cval;
				R_SCUR:   scur_q   <= cval[11:0];
				R_SDLY:   sdly_q   <= cval;
				R_FAULT:  fault_q  <= cval;
				R_STEMP:  stemp_q  <= signed'(cval[7:0]);
				R_TARGET: target_q <= cval;
				default: ;
			endcase
		end
	end

	// state
	status_t status_q;
	motion_t motion_q;
	jog_t    jog_q;
	logic    pos_q, mrun_q, crun_q;
	logic [15:0] cyc_q, cnt_q;
	logic [TB-1:0] mms_q, cms_q;
	logic [16:0] jms_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [11:0] mean_q;
	logic signed [15:0] peak_q;
	logic [1:0] lines_q;

	// next state
	status_t status_d;
	motion_t motion_d;
	jog_t    jog_d;
	logic    pos_d, mrun_d, crun_d;
	logic [15:0] cyc_d, cnt_d;
	logic [TB-1:0] mms_d, cms_d;
	logic [16:0] jms_d;
	logic [SUM_BITS-1:0] sum_d;
	logic signed [15:0] peak_d;
	logic [1:0] lines_d;
	logic need_div;
	// sum and count as they stand when the current stop fires
	logic [SUM_BITS-1:0] dsum_d;
	logic [CNT_BITS-1:0] dcnt_d;

	seq_t seq_q, seq_d;
	logic out_valid_q;
	logic div_start, div_busy;
	logic [SUM_BITS-1:0] quo;

	logic in_fire;
	assign in_ch.ready = (seq_q == SQ_IDLE) && !out_valid_q;
	assign in_fire = in_ch.valid && in_ch.ready;

	// jog helpers inline; whole item decision in one combinational pass
	always_comb begin
		logic [16:0] dur;
		logic [15:0] tgt;
		logic        go;
		status_d = status_q; motion_d = motion_q; jog_d = jog_q; pos_d = pos_q;
		mrun_d = mrun_q; crun_d = crun_q; cyc_d = cyc_q; cnt_d = cnt_q;
		mms_d = mms_q; cms_d = cms_q; jms_d = jms_q; sum_d = sum_q;
		peak_d = peak_q; lines_d = lines_q; need_div = 1'b0;
		dsum_d = sum_q; dcnt_d = cnt_q;
		dur = 17'd0; go = 1'b0;
		tgt = target_q;
		if (jog_q != JOG_NONE) begin
			if (op_t'(operation) == OP_TICK) begin
				if (jms_d != 17'd0) jms_d = jms_d - 17'd1;
				if (jms_d == 17'd0) begin
					lines_d = 2'd0; motion_d = MO_IDLE;
					pos_d = (jog_q == JOG_CLOSE);
					mms_d = '0; mrun_d = 1'b0; cms_d = '0; crun_d = 1'b0;
					status_d = ST_PAUSED;
					if (jog_q == JOG_HOME) begin
						status_d = ST_RUN; crun_d = 1'b1;
					end
					jog_d = JOG_NONE;
				end
			end
		end else begin
			unique case (operation)
				OP_TICK: begin
					if (mrun_d && mms_d != TMAX) mms_d = mms_d + TB'(1);
					if (crun_d && cms_d != TMAX) cms_d = cms_d + TB'(1);
					if (status_d == ST_RUN && mode_q == 2'd1) begin
						if (cnt_d != 16'hFFFF) begin
							cnt_d = cnt_d + 16'd1;
							sum_d = sum_d + SUM_BITS'(cur_s);
						end
						if (grip_force > peak_d) peak_d = grip_force;
						if (cur_s >= scur_q &&
						    {16'd0, mms_d} >= {(TB)'(0), sdly_q}) begin
							need_div = 1'b1;
							dsum_d = sum_d; dcnt_d = cnt_d;
							lines_d = 2'd0;
							if (motion_d == MO_OPEN) begin
								pos_d = 1'b0;
								if (cyc_d != 16'hFFFF) cyc_d = cyc_d + 16'd1;
							end else if (motion_d == MO_CLOSE) pos_d = 1'b1;
							motion_d = MO_IDLE;
							cms_d = '0; crun_d = 1'b1; mrun_d = 1'b0;
						end
						if (motion_d == MO_IDLE &&
						    {16'd0, cms_d} >= {(TB)'(0), cool_t_q}) begin
							crun_d = 1'b0; mms_d = '0; mrun_d = 1'b1;
							if (!pos_d) begin
								sum_d = '0; cnt_d = '0; peak_d = '0;
								motion_d = MO_CLOSE; lines_d = 2'd1;
							end else begin
								motion_d = MO_OPEN; lines_d = 2'd2;
							end
						end
						if ({16'd0, mms_d} >= {(TB)'(0), fault_q}) begin
							lines_d = 2'd0;
							if (motion_d == MO_OPEN) pos_d = 1'b0;
							else if (motion_d == MO_CLOSE) pos_d = 1'b1;
							motion_d = MO_IDLE;
							mms_d = '0; mrun_d = 1'b0; cms_d = '0; crun_d = 1'b0;
							status_d = ST_FAULT;
						end
					end else if (status_d == ST_RUN && mode_q == 2'd2) begin
						if ({16'd0, cms_d} >= {(TB)'(0), cool_t_q} &&
						    motion_d == MO_IDLE) begin
							if (!pos_d) begin
								motion_d = MO_CLOSE; lines_d = 2'd1;
							end else begin
								motion_d = MO_OPEN; lines_d = 2'd2;
							end
							cms_d = '0; crun_d = 1'b0; mms_d = '0; mrun_d = 1'b1;
						end
						if (motion_d != MO_IDLE &&
						    {16'd0, mms_d} >= {(TB)'(0), move_q}) begin
							if (motion_d == MO_OPEN) begin
								pos_d = 1'b0;
								if (cyc_d != 16'hFFFF) cyc_d = cyc_d + 16'd1;
							end else pos_d = 1'b1;
							motion_d = MO_IDLE; lines_d = 2'd0;
							mms_d = '0; mrun_d = 1'b0; cms_d = '0; crun_d = 1'b1;
						end
					end
					if (status_d != ST_HOT && temperature >= stemp_q) begin
						status_d = ST_HOT; lines_d = 2'd0; motion_d = MO_IDLE;
						mms_d = '0; mrun_d = 1'b0; cms_d = '0; crun_d = 1'b0;
					end
					if (status_d == ST_RUN && tgt != 16'd0 && cyc_d >= tgt) begin
						status_d = ST_DONE; motion_d = MO_IDLE;
						mrun_d = 1'b0; crun_d = 1'b0; lines_d = 2'd0;
					end
				end
				OP_START: begin
					if (status_d == ST_STOPPED || status_d == ST_DONE) begin
						go = 1'b1; jog_d = JOG_HOME; dur = {move_q, 1'b0};
						cyc_d = 16'd0;
					end else begin
						status_d = ST_RUN; crun_d = 1'b1;
					end
				end
				OP_PAUSE, OP_STOP: begin
					status_d = (operation == OP_PAUSE) ? ST_PAUSED : ST_STOPPED;
					motion_d = MO_IDLE; mrun_d = 1'b0; crun_d = 1'b0; lines_d = 2'd0;
				end
				OP_JOG_OPEN, OP_JOG_CLOSE: begin
					go = 1'b1; dur = {1'b0, move_q};
					jog_d = (operation == OP_JOG_CLOSE) ? JOG_CLOSE : JOG_OPEN;
					status_d = ST_PAUSED;
				end
				default: ;
			endcase
			if (go) begin
				jms_d = dur;
				mms_d = '0; mrun_d = 1'b0; cms_d = '0; crun_d = 1'b0;
				lines_d = (jog_d == JOG_CLOSE) ? 2'd1 : 2'd2;
				motion_d = (jog_d == JOG_CLOSE) ? MO_CLOSE : MO_OPEN;
				if (dur == 17'd0) begin
					lines_d = 2'd0; motion_d = MO_IDLE;
					pos_d = (jog_d == JOG_CLOSE);
					crun_d = (jog_d == JOG_HOME);
					status_d = (jog_d == JOG_HOME) ? ST_RUN : ST_PAUSED;
					jog_d = JOG_NONE;
				end
			end
		end
	end

	// sequencer
	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SQ_IDLE: if (in_fire && need_div) seq_d = SQ_DIV;
			SQ_DIV:  if (!div_busy && !div_start) seq_d = SQ_DONE;
			SQ_DONE: seq_d = SQ_IDLE;
			default: seq_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		unique case (seq_q)
			SQ_IDLE: div_start = 1'b0;
			SQ_DIV:  div_start = 1'b0;
			SQ_DONE: div_start = 1'b0;
			default: div_start = 1'b0;
		endcase
		if (in_fire && need_div) div_start = 1'b1;
	end

	aets_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(dsum_d), .divisor(dcnt_d), .busy(div_busy), .quotient(quo)
	);

	// mean clamp: divide by zero gives all ones which clamps too, but zero count
	// must read zero
	logic [11:0] mean_new;
	logic        zero_cnt_q;
	always_comb begin
		if (zero_cnt_q) mean_new = 12'd0;
		else if (quo > SUM_BITS'(CUR_MASK)) mean_new = CUR_MASK;
		else mean_new = quo[11:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_STOPPED; motion_q <= MO_IDLE; jog_q <= JOG_NONE;
			pos_q <= 1'b0; mrun_q <= 1'b0; crun_q <= 1'b1;
			cyc_q <= '0; cnt_q <= '0; mms_q <= '0; cms_q <= '0; jms_q <= '0;
			sum_q <= '0; mean_q <= '0; peak_q <= '0; lines_q <= '0;
			seq_q <= SQ_IDLE; out_valid_q <= 1'b0; zero_cnt_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			if (in_fire) begin
				status_q <= status_d; motion_q <= motion_d; jog_q <= jog_d;
				pos_q <= pos_d; mrun_q <= mrun_d; crun_q <= crun_d;
				cyc_q <= cyc_d; cnt_q <= cnt_d; mms_q <= mms_d; cms_q <= cms_d;
				jms_q <= jms_d; sum_q <= sum_d; peak_q <= peak_d; lines_q <= lines_d;
				zero_cnt_q <= (dcnt_d == 16'd0);
				if (!need_div) out_valid_q <= 1'b1;
			end else if (seq_q == SQ_DONE) begin
				mean_q <= mean_new;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = {lines_q[0], lines_q[1], status_q, motion_q, pos_q,
	                      cyc_q, mean_q, peak_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ch.ready) else $error("took a word while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != SQ_IDLE) |-> !out_valid_q) else $error("result during divide");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(lines_q[0] && lines_q[1])) else $error("both drive lines on");
	assert property (@(posedge clk) disable iff (!arst_n)
		(motion_q == MO_IDLE) |-> (lines_q == 2'd0)) else $error("idle but driving");
endmodule
`default_nettype wire

>>> verif/tb_chan_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_chan_if: note on the channels used by the testbench
// the block's own valid/ready interface from aets_if is reused for all three
// channels, so this file only holds the testbench's word layouts
// ---------------------------------------------------------------------------
package tb_word_pkg;
	// input word, first field in the top bits
	typedef struct packed {
		logic [2:0]         op;
		logic [11:0]        cur;
		logic signed [15:0] grip;
		logic signed [7:0]  temp;
	} cmd_word_t;

	// status word, first field in the top bits
	typedef struct packed {
		logic               drv_close;
		logic               drv_open;
		logic [2:0]         status;
		logic [1:0]         motion;
		logic               position;
		logic [15:0]        cycles;
		logic [11:0]        mean;
		logic signed [15:0] peak;
	} stat_word_t;
endpackage

>>> verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: endurance test sequencer testbench
// drives ticks and commands in bursts, predicts every status word with a
// word-level software copy of the sequencer, and checks each one field by
// field while the receiver stalls at random
// ---------------------------------------------------------------------------
module tb;
	import aets_pkg::*;
	import tb_word_pkg::*;

	localparam int LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	aets_if #(.W(39)) in_ch();
	aets_if #(.W(52)) out_ch();
	aets_if #(.W(19)) cfg_ch();

	actuator_endurance_test_sequencer_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// setup register copy
	logic [1:0]         cf_mode;
	logic [15:0]        cf_move, cf_cool, cf_sdly, cf_fault, cf_target;
	logic [11:0]        cf_scur;
	logic signed [7:0]  cf_stemp;

	// sequencer state copy
	status_t     st;
	motion_t     mot;
	jog_t        jog;
	logic        pos, mot_run, cool_run;
	logic [1:0]  lines;
	int unsigned cycles, mot_ms, cool_ms, jog_ms, samples, mean;
	longint unsigned cur_sum;
	int          peak;

	cmd_word_t  pending_q[$];
	stat_word_t status_q[$];
	int         mismatches = 0;
	int         issued = 0;
	longint     cyc = 0;

	function automatic void halt_timers();
		mot_ms = 0; mot_run = 0;
		cool_ms = 0; cool_run = 0;
	endfunction

	function automatic void end_jog();
		lines = 2'b00;
		mot = MO_IDLE;
		pos = (jog == JOG_CLOSE);
		halt_timers();
		st = ST_PAUSED;
		// homing after a start hands over to running with cooling active
		if (jog == JOG_HOME) begin
			st = ST_RUN;
			cool_run = 1;
		end
		jog = JOG_NONE;
		jog_ms = 0;
	endfunction

	function automatic void start_jog(jog_t kind, int unsigned dur);
		jog = kind;
		jog_ms = dur;
		halt_timers();
		lines = (kind == JOG_CLOSE) ? 2'b01 : 2'b10;
		mot = (kind == JOG_CLOSE) ? MO_CLOSE : MO_OPEN;
		if (kind == JOG_HOME)
			cycles = 0;
		else
			st = ST_PAUSED;
		if (dur == 0)
			end_jog();
	endfunction

	function automatic void halt_motion();
		st = ST_STOPPED;
		mot = MO_IDLE;
		mot_run = 0;
		cool_run = 0;
		lines = 2'b00;
	endfunction

	function automatic void bump_cycles();
		if (cycles < 65535)
			cycles++;
	endfunction

	// current-limited mode, one tick
	function automatic void current_tick(int unsigned cur, int grip);
		longint unsigned m;
		if (samples < 65535) begin
			samples++;
			cur_sum += cur;
		end
		if (grip > peak)
			peak = grip;
		if (cur >= cf_scur && mot_ms >= cf_sdly) begin
			m = (samples != 0) ? cur_sum / samples : 0;
			if (m > 4095)
				m = 4095;
			mean = 32'(m);
			lines = 2'b00;
			if (mot == MO_OPEN) begin
				pos = 0;
				bump_cycles();
			end else if (mot == MO_CLOSE) begin
				pos = 1;
			end
			mot = MO_IDLE;
			cool_ms = 0; cool_run = 1;
			mot_run = 0;
		end
		if (mot == MO_IDLE && cool_ms >= cf_cool) begin
			cool_run = 0;
			mot_ms = 0; mot_run = 1;
			if (!pos) begin
				// a close starts a fresh cycle of statistics
				cur_sum = 0; samples = 0; peak = 0;
				mot = MO_CLOSE; lines = 2'b01;
			end else begin
				mot = MO_OPEN; lines = 2'b10;
			end
		end
		// stuck move
		if (mot_ms >= cf_fault) begin
			lines = 2'b00;
			if (mot == MO_OPEN)
				pos = 0;
			else if (mot == MO_CLOSE)
				pos = 1;
			mot = MO_IDLE;
			halt_timers();
			st = ST_FAULT;
		end
	endfunction

	// timed mode, one tick
	function automatic void timed_tick();
		if (cool_ms >= cf_cool && mot == MO_IDLE) begin
			if (!pos) begin
				mot = MO_CLOSE; lines = 2'b01;
			end else begin
				mot = MO_OPEN; lines = 2'b10;
			end
			cool_ms = 0; cool_run = 0;
			mot_ms = 0; mot_run = 1;
		end
		if (mot != MO_IDLE && mot_ms >= cf_move) begin
			if (mot == MO_OPEN) begin
				pos = 0;
				bump_cycles();
			end else begin
				pos = 1;
			end
			mot = MO_IDLE;
			lines = 2'b00;
			mot_ms = 0; mot_run = 0;
			cool_ms = 0; cool_run = 1;
		end
	endfunction

	// next status word for one accepted input word
	function automatic stat_word_t sequence_word(cmd_word_t w);
		stat_word_t r;
		if (jog != JOG_NONE) begin
			// blocking move: only ticks count it down, commands are dropped
			if (w.op == OP_TICK) begin
				if (jog_ms > 0)
					jog_ms--;
				if (jog_ms == 0)
					end_jog();
			end
		end else begin
			case (w.op)
				OP_TICK: begin
					if (mot_run && mot_ms < 65535)
						mot_ms++;
					if (cool_run && cool_ms < 65535)
						cool_ms++;
					if (st == ST_RUN) begin
						if (cf_mode == 2'd1)
							current_tick(w.cur, w.grip);
						else if (cf_mode == 2'd2)
							timed_tick();
					end
					if (st != ST_HOT && w.temp >= cf_stemp) begin
						st = ST_HOT;
						lines = 2'b00;
						mot = MO_IDLE;
						halt_timers();
					end
					if (st == ST_RUN && cf_target != 0 && cycles >= cf_target) begin
						halt_motion();
						st = ST_DONE;
					end
				end
				OP_START: begin
					if (st == ST_STOPPED || st == ST_DONE) begin
						start_jog(JOG_HOME, 2 * int'(cf_move));
					end else begin
						st = ST_RUN;
						cool_run = 1;
					end
				end
				OP_PAUSE: begin
					halt_motion();
					st = ST_PAUSED;
				end
				OP_STOP: halt_motion();
				OP_JOG_OPEN: start_jog(JOG_OPEN, cf_move);
				OP_JOG_CLOSE: start_jog(JOG_CLOSE, cf_move);
				default: ;
			endcase
		end
		r.drv_close = lines[0];
		r.drv_open  = lines[1];
		r.status    = st;
		r.motion    = mot;
		r.position  = pos;
		r.cycles    = cycles[15:0];
		r.mean      = mean[11:0];
		r.peak      = peak[15:0];
		return r;
	endfunction

	function automatic void load_reg(reg_t idx, logic [15:0] v);
		case (idx)
			R_MODE:   cf_mode = v[1:0];
			R_MOVE:   cf_move = v;
			R_COOL:   cf_cool = v;
			R_SCUR:   cf_scur = v[11:0];
			R_SDLY:   cf_sdly = v;
			R_FAULT:  cf_fault = v;
			R_STEMP:  cf_stemp = v[7:0];
			R_TARGET: cf_target = v;
			default: ;
		endcase
	endfunction

	initial begin
		cf_mode = 2'd1; cf_move = 600; cf_cool = 1000; cf_scur = 4095;
		cf_sdly = 100; cf_fault = 5000; cf_stemp = 60; cf_target = 0;
		st = ST_STOPPED; mot = MO_IDLE; jog = JOG_NONE; pos = 0;
		mot_run = 0; cool_run = 1; lines = 2'b00;
		cycles = 0; mot_ms = 0; cool_ms = 0; jog_ms = 0;
		samples = 0; mean = 0; cur_sum = 0; peak = 0;
	end

	// driver: bursts of words with random gaps, hold-off on request
	int gap_left = 0;
	int burst_left = 4;
	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
	end
	always @(posedge clk) begin
		if (!in_ch.valid || in_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				in_ch.data <= pending_q.pop_front();
				in_ch.valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					// some bursts are followed by no gap at all
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: long always-ready stretches, random stalls elsewhere
	initial out_ch.ready = 1'b0;
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc[9:8] == 2'd0)
			out_ch.ready <= 1'b1;
		else if (cyc[9:8] == 2'd3)
			out_ch.ready <= ($urandom_range(0, 7) == 0);
		else
			out_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	// monitor: predict on input accept, check on output accept
	always @(posedge clk) begin
		stat_word_t got, want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				load_reg(reg_t'(cfg_ch.data[18:16]), cfg_ch.data[15:0]);
			if (in_ch.valid && in_ch.ready)
				status_q.push_back(sequence_word(cmd_word_t'(in_ch.data)));
			if (out_ch.valid && out_ch.ready) begin
				got = stat_word_t'(out_ch.data);
				if (status_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected status word %h", got);
				end else begin
					want = status_q.pop_front();
					if (got.drv_close !== want.drv_close || got.drv_open !== want.drv_open ||
					    got.status !== want.status || got.motion !== want.motion ||
					    got.position !== want.position || got.cycles !== want.cycles ||
					    got.mean !== want.mean || got.peak !== want.peak) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: lines %b%b/%b%b st %0d/%0d mo %0d/%0d pos %0d/%0d cyc %0d/%0d mean %0d/%0d peak %0d/%0d",
								want.drv_open, want.drv_close, got.drv_open, got.drv_close,
								want.status, got.status, want.motion, got.motion,
								want.position, got.position, want.cycles, got.cycles,
								want.mean, got.mean, want.peak, got.peak);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cyc >= LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic write_reg(reg_t idx, logic [15:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= {idx, v};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// sender holds off until every status word is back, then the tail latency
	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() != 0 || in_ch.valid || status_q.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic push_word(op_t op, int cur, int grip, int temp);
		cmd_word_t w;
		w.op = op; w.cur = cur; w.grip = grip; w.temp = temp;
		pending_q.push_back(w);
		issued++;
	endtask

	// tick with random samples, mostly below the heat limit
	task automatic push_tick(bit cool_only);
		int t;
		if (cool_only || $urandom_range(0, 40) != 0)
			t = (int'(cf_stemp) > -128) ? $urandom_range(0, int'(cf_stemp) + 127) - 128 : -128;
		else
			t = $urandom_range(0, 255) - 128;
		push_word(OP_TICK, $urandom_range(0, 4095), $urandom_range(0, 65535), t);
	endtask

	task automatic write_all(int m, int mv, int cl, int sc, int sd, int ft, int stp, int tg);
		write_reg(R_MODE, m);
		write_reg(R_MOVE, mv);
		write_reg(R_COOL, cl);
		write_reg(R_SCUR, sc);
		write_reg(R_SDLY, sd);
		write_reg(R_FAULT, ft);
		write_reg(R_STEMP, stp & 8'hff);
		write_reg(R_TARGET, tg);
	endtask

	initial begin
		int phase_no, n, k, mode_pick;
		bit long_moves;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: short moves, small cycle target
		write_all(1, 2, 1, 100, 1, 8, 50, 2);
		push_word(OP_TICK, 4095, 32767, -128);
		push_word(OP_TICK, 0, -32768, 127);
		push_word(OP_START, 0, 0, 0);
		push_word(OP_PAUSE, 0, 0, 0);
		repeat (4) push_word(OP_TICK, 0, 0, 0);
		push_word(OP_TICK, 50, 1000, 20);
		push_word(OP_TICK, 4095, -5, 20);
		push_word(OP_TICK, 4095, 2000, 20);
		push_word(OP_PAUSE, 0, 0, 0);
		push_word(OP_START, 0, 0, 0);
		push_word(OP_JOG_CLOSE, 0, 0, 0);
		push_word(OP_STOP, 0, 0, 0);
		repeat (2) push_word(OP_TICK, 0, 0, 0);
		push_word(OP_JOG_OPEN, 0, 0, 0);
		repeat (2) push_word(OP_TICK, 0, 0, 0);
		push_word(op_t'(3'd6), 4095, 1, 1);
		push_word(op_t'(3'd7), 4095, 1, 1);
		push_word(OP_START, 0, 0, 0);
		push_word(OP_TICK, 10, 3, 50);
		push_word(OP_START, 0, 0, 0);
		push_word(OP_STOP, 0, 0, 0);
		drain();
		// zero-length jogs and homing
		write_reg(R_MOVE, 0);
		push_word(OP_JOG_CLOSE, 0, 0, 0);
		push_word(OP_JOG_OPEN, 0, 0, 0);
		push_word(OP_STOP, 0, 0, 0);
		push_word(OP_START, 0, 0, 0);
		drain();

		phase_no = 0;
		while (issued < 1850) begin
			phase_no++;
			long_moves = 0;
			case (phase_no)
				1: begin
					// longest move time, timed mode: a move never ends
					write_all(2, 65535, 0, 2000, 0, 65535, 100, 0);
					long_moves = 1;
				end
				2: write_all(1, 3, 65535, 3000, 2, 30, 120, 0);
				3: write_all(1, 2, 0, 0, 0, 0, -128, 1);
				4: write_all(1, 4, 2, 4095, 65535, 65535, 127, 65535);
				5: write_all(3, 2, 1, 1000, 1, 20, 80, 0);
				6: write_all(1, 3, 3, 4095, 0, 12, 127, 3);
				default: begin
					mode_pick = $urandom_range(0, 7);
					write_all((mode_pick == 0) ? 0 : (mode_pick < 5) ? 1 : 2,
						$urandom_range(0, 6), $urandom_range(0, 6),
						$urandom_range(0, 4095), $urandom_range(0, 8),
						$urandom_range(0, 40), $urandom_range(20, 127),
						$urandom_range(0, 6));
				end
			endcase
			if (long_moves) begin
				// no homing or jogs here: pause then start never homes
				push_word(OP_PAUSE, 0, 0, 0);
				push_word(OP_START, 0, 0, 0);
			end else begin
				push_word(OP_START, 0, 0, 0);
			end
			n = $urandom_range(80, 200);
			for (int i = 0; i < n; i++) begin
				k = $urandom_range(0, 99);
				if (k < 84)
					push_tick(long_moves);
				else if (long_moves) begin
					if (k < 92) begin
						push_word(OP_PAUSE, 0, 0, 0);
						push_word(OP_START, 0, 0, 0);
					end else begin
						push_word(op_t'($urandom_range(6, 7)), $urandom_range(0, 4095),
							$urandom_range(0, 65535), $urandom_range(0, 255));
					end
				end else if (k < 89)
					push_word(OP_START, $urandom_range(0, 4095), $urandom_range(0, 65535),
						$urandom_range(0, 255));
				else if (k < 91)
					push_word(OP_PAUSE, 0, 0, 0);
				else if (k < 93)
					push_word(OP_STOP, 0, 0, 0);
				else if (k < 96)
					push_word(OP_JOG_OPEN, 0, 0, 0);
				else if (k < 99)
					push_word(OP_JOG_CLOSE, 0, 0, 0);
				else
					push_word(op_t'($urandom_range(6, 7)), $urandom_range(0, 4095),
						$urandom_range(0, 65535), $urandom_range(0, 255));
			end
			drain();
		end

		if (mismatches == 0 && status_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

>>> filelist.f
rtl/core/aets_pkg.sv
rtl/core/aets_if.sv
rtl/core/aets_div.sv
rtl/core/actuator_endurance_test_sequencer_unit.sv
verif/tb_chan_if.sv
verif/tb.sv
